// ===== sv/pse_pkg.sv =====
// shared constants for the postfix stack evaluator
package pse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int ST_W        = 3;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OP_W-1:0] OP_EQ   = 3'd5;

	localparam logic [ST_W-1:0] ST_ACCEPTED   = 3'd0;
	localparam logic [ST_W-1:0] ST_RESULT     = 3'd1;
	localparam logic [ST_W-1:0] ST_TOO_FEW    = 3'd2;
	localparam logic [ST_W-1:0] ST_DIV_ZERO   = 3'd3;
	localparam logic [ST_W-1:0] ST_EXPR_ERROR = 3'd4;
	localparam logic [ST_W-1:0] ST_TOO_MANY   = 3'd5;
	localparam logic [ST_W-1:0] ST_EMPTY      = 3'd6;
	localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd7;

endpackage

// ===== sv/postfix_stack_evaluator.sv =====
// postfix expression evaluator with an operand stack held in a synchronous ram
// Input channel in_valid/in_ready carries one token per beat: operation and
// operand_value. Output channel out_valid/out_ready carries one answer per
// token: status and result_value (zero unless status is result).
// Tokens are handled one at a time by a sequencer around the stack ram,
// which has one write and one registered read port.
// Steps from accept to output valid:
//   push, invalid token, equals without a read: straight to the answer
//   equals that pops the final value: one ram read
//   add, subtract, multiply: two ram reads, execute, write back
//   divide: adds the 32-step radix-2 divider, which a divide by zero skips
// With out_ready high the sequencer returns to idle as the answer goes out.
// A new token is accepted as soon as the sequencer is idle, even while the
// previous answer still waits in the output register; the sequencer holds
// its next answer until that register is taken.
// Reset clears the stack count, the error flag and the output valid flag; the
// stack ram itself is not cleared, only entries below the count are read.
// When out_ready stays low the answer holds and at most one more token is
// taken in before in_ready drops.
module postfix_stack_evaluator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pse_pkg::OP_W-1:0]          operation,
	input  logic signed [pse_pkg::DATA_W-1:0] operand_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pse_pkg::ST_W-1:0]          status,
	output logic signed [pse_pkg::DATA_W-1:0] result_value
);
	import pse_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_EQRD = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              err_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] right_q;
	logic [DATA_W-1:0] res_q;
	logic [ST_W-1:0]   st_q;
	logic [DATA_W-1:0] outval_q;
	logic [DATA_W-1:0] rdata_q;

	logic              accept;
	logic              is_arith;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic              out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_arith = operation inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
	assign cnt_m1   = count_q - 1'b1;
	assign cnt_m2   = count_q - CNT_W'(2);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_m1[PTR_W-1:0];
		if (state_q == S_IDLE && accept) begin
			if (is_arith && count_q >= CNT_W'(2)) begin
				rd_en = 1'b1;
			end else if (operation == OP_EQ && !err_q && count_q == CNT_W'(1)) begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
		end else if (state_q == S_RD1) begin
			rd_en   = 1'b1;
			rd_addr = cnt_m2[PTR_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[PTR_W-1:0];
		wr_data = operand_value;
		if (accept && operation == OP_PUSH && count_q < CNT_W'(STACK_DEPTH)) begin
			wr_en = 1'b1;
		end else if (state_q == S_WB) begin
			wr_en   = 1'b1;
			wr_addr = cnt_m2[PTR_W-1:0];
			wr_data = res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= stack_mem[rd_addr];
		end
	end

	assign div_start = (state_q == S_EXEC) && (op_q == OP_DIV) && (right_q != '0);

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rdata_q),
		.divisor  (right_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			err_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						case (operation)
							OP_PUSH: begin
								if (count_q >= CNT_W'(STACK_DEPTH)) begin
									err_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
								if (count_q >= CNT_W'(2)) begin
									state_q <= S_RD1;
								end
							end
							OP_EQ: begin
								if (err_q) begin
									err_q   <= 1'b0;
									count_q <= '0;
								end else if (count_q > CNT_W'(1)) begin
									count_q <= '0;
								end else if (count_q == CNT_W'(1)) begin
									state_q <= S_EQRD;
								end
							end
							default: begin
								err_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD1: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_WB;
						if (op_q == OP_DIV) begin
							err_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					count_q <= cnt_m1;
					state_q <= S_FIN;
				end
				S_EQRD: begin
					count_q <= '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= operation;
					outval_q <= '0;
					st_q     <= ST_ACCEPTED;
					case (operation)
						OP_PUSH: begin
							if (count_q >= CNT_W'(STACK_DEPTH)) begin
								st_q <= ST_OVERFLOW;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (count_q < CNT_W'(2)) begin
								st_q <= ST_TOO_FEW;
							end
						end
						OP_EQ: begin
							if (err_q) begin
								st_q <= ST_EXPR_ERROR;
							end else if (count_q > CNT_W'(1)) begin
								st_q <= ST_TOO_MANY;
							end else if (count_q == '0) begin
								st_q <= ST_EMPTY;
							end else begin
								st_q <= ST_RESULT;
							end
						end
						default: begin
							st_q <= ST_ACCEPTED;
						end
					endcase
				end
			end
			S_RD1: begin
				right_q <= rdata_q;
			end
			S_EXEC: begin
				case (op_q)
					OP_ADD:  res_q <= rdata_q + right_q;
					OP_SUB:  res_q <= rdata_q - right_q;
					OP_MUL:  res_q <= DATA_W'(rdata_q * right_q);
					default: begin
						res_q <= '0;
						if (right_q == '0) begin
							st_q <= ST_DIV_ZERO;
						end
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					res_q <= div_quo;
				end
			end
			S_EQRD: begin
				outval_q <= rdata_q;
			end
			S_FIN: begin
				if (out_free) begin
					status       <= st_q;
					result_value <= outval_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/pse_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module pse_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pse_pkg::DATA_W-1:0] dividend,
	input  logic [pse_pkg::DATA_W-1:0] divisor,
	output logic                       done,
	output logic [pse_pkg::DATA_W-1:0] quotient
);
	import pse_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic                 neg_q;

	logic [DATA_W-1:0] lmag;
	logic [DATA_W-1:0] rmag;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	assign lmag    = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign rmag    = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= lmag;
			dvs_q <= rmag;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
